// ===== hdl/dsss_pkg.sv =====
`timescale 1ns / 1ps

package dsss_pkg;

	localparam int DIGITS  = 6;
	localparam int IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int VALUE_W = 22;
	localparam int CODE_W  = 8;
	localparam int CFG_W   = 16;

	localparam logic [7:0] GRID_FIRST = 8'(1 << (DIGITS - 1));
	localparam logic [7:0] GRID_BLANK = ~GRID_FIRST;

	// Reciprocal of ten: floor(x * DIV10_MULT / 2**DIV10_SHIFT) == x / 10
	// for every x below 2**VALUE_W.
	localparam int               DIV10_SHIFT = 26;
	localparam logic [22:0]      DIV10_MULT  = 23'd6710887;
	localparam int               PROD_W      = VALUE_W + 23;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_TICK = 1'b1
	} req_t;

	typedef enum logic {
		REG_DWELL_TICKS  = 1'b0,
		REG_TOTAL_ROUNDS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             scan;
		logic [IDX_W-1:0] idx;
	} scan_t;

	typedef struct packed {
		logic                          valid;
		logic                          is_load;
		scan_t                         view;
		logic [VALUE_W-1:0]            rest;
		logic [DIGITS-1:0][CODE_W-1:0] codes;
	} stage_t;

	localparam logic [CODE_W-1:0] SEG_TABLE [32] = '{
		8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he4,
		8'hfe, 8'hf6, 8'hfa, 8'h3e, 8'h1a, 8'h7a, 8'h9e, 8'h8e,
		8'h0c, 8'h3a, 8'h26, 8'h4a, 8'h70, 8'he0, 8'h0e, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	function automatic logic [CODE_W-1:0] glyph(input logic [VALUE_W-1:0] d);
		logic [CODE_W-1:0] g;
		g = '0;
		if (d < VALUE_W'(32)) begin
			g = SEG_TABLE[d[4:0]];
		end
		return g;
	endfunction

endpackage

// ===== hdl/dsss_cell.sv =====
`timescale 1ns / 1ps

module dsss_cell
	import dsss_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  stage_t d,
	output stage_t q
);

	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] quot;
	logic [VALUE_W-1:0] diff;
	stage_t             nxt;

	// Each cell peels off the lowest decimal digit and shifts its glyph in
	// at the top of the code row.
	always_comb begin
		prod = PROD_W'(d.rest) * PROD_W'(DIV10_MULT);
		quot = VALUE_W'(prod >> DIV10_SHIFT);
		diff = d.rest - ((quot << 3) + (quot << 1));
		nxt = d;
		nxt.rest = quot;
		for (int i = 0; i < DIGITS - 1; i++) begin
			nxt.codes[i] = d.codes[i+1];
		end
		nxt.codes[DIGITS-1] = glyph({{(VALUE_W-4){1'b0}}, diff[3:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (advance) begin
			q <= nxt;
		end
	end

endmodule

// ===== hdl/dsss_ctrl.sv =====
`timescale 1ns / 1ps

module dsss_ctrl
	import dsss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             accept,
	input  logic             req_type,
	input  logic             value_nonzero,
	output scan_t            view
);

	logic [CFG_W-1:0] dwell_ticks_q;
	logic [CFG_W-1:0] total_rounds_q;
	logic [CFG_W-1:0] dwell_q;
	logic [CFG_W-1:0] round_q;
	logic [IDX_W-1:0] idx_q;
	logic             scan_q;

	logic [CFG_W-1:0] dwell_d;
	logic [CFG_W-1:0] round_d;
	logic [IDX_W-1:0] idx_d;
	logic             scan_d;
	logic [CFG_W:0]   dwell_inc;
	logic [CFG_W:0]   round_inc;

	always_comb begin
		dwell_inc = {1'b0, dwell_q} + 1'b1;
		round_inc = {1'b0, round_q} + 1'b1;
		dwell_d = dwell_q;
		round_d = round_q;
		idx_d = idx_q;
		scan_d = scan_q;
		if (req_type == REQ_LOAD) begin
			dwell_d = '0;
			round_d = '0;
			idx_d = '0;
			scan_d = value_nonzero;
		end else if (scan_q) begin
			if (dwell_inc >= {1'b0, dwell_ticks_q}) begin
				dwell_d = '0;
				if (idx_q == IDX_W'(DIGITS - 1)) begin
					idx_d = '0;
					if (round_inc >= {1'b0, total_rounds_q}) begin
						round_d = '0;
						scan_d = 1'b0;
					end else begin
						round_d = round_inc[CFG_W-1:0];
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end else begin
				dwell_d = dwell_inc[CFG_W-1:0];
			end
		end
		view.scan = scan_d;
		view.idx = idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q <= CFG_W'(1);
			total_rounds_q <= CFG_W'(867);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DWELL_TICKS:  dwell_ticks_q <= cfg_data;
				REG_TOTAL_ROUNDS: total_rounds_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q <= '0;
			round_q <= '0;
			idx_q <= '0;
			scan_q <= 1'b0;
		end else if (accept) begin
			dwell_q <= dwell_d;
			round_q <= round_d;
			idx_q <= idx_d;
			scan_q <= scan_d;
		end
	end

endmodule

// ===== hdl/decimal_seven_segment_scanner.sv =====
`timescale 1ns / 1ps
// Path: input register, digit cells, output register; one result per item.
// Throughput: one item per cycle; the digit cells form a pipeline stalled only by out_stall.
// The scan counters update in the cycle of the transfer; the last digit is decoded after the cells.
// Reset: dwell_ticks 1, total_rounds 867, scan stopped, display blank (grid 0xDF, segments 0).

module decimal_seven_segment_scanner
	import dsss_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         grid_select,
	output logic [7:0]         segment_pattern,
	output logic               busy_res,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	logic                          advance;
	logic                          accept;
	scan_t                         view;
	stage_t                        st [DIGITS];
	stage_t                        last;
	logic [DIGITS-1:0][CODE_W-1:0] codes_q;
	logic [DIGITS-1:0][CODE_W-1:0] codes_new;
	logic [DIGITS-1:0][CODE_W-1:0] codes_sel;
	logic [7:0]                    grid_d;
	logic [7:0]                    seg_d;

	assign advance = !(out_valid && out_stall);
	assign in_stall = !advance;
	assign accept = in_valid && advance;

	dsss_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.req_type      (req_type),
		.value_nonzero (value != '0),
		.view          (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st[0] <= '0;
		end else if (advance) begin
			st[0].valid <= in_valid;
			st[0].is_load <= (req_type == REQ_LOAD);
			st[0].view <= view;
			st[0].rest <= value;
			st[0].codes <= '0;
		end
	end

	for (genvar k = 0; k < DIGITS - 1; k++) begin : g_cell
		dsss_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.d       (st[k]),
			.q       (st[k+1])
		);
	end

	assign last = st[DIGITS-1];

	always_comb begin
		for (int i = 0; i < DIGITS - 1; i++) begin
			codes_new[i] = last.codes[i+1];
		end
		codes_new[DIGITS-1] = glyph(last.rest);
		codes_sel = last.is_load ? codes_new : codes_q;
		if (last.view.scan) begin
			grid_d = GRID_FIRST >> last.view.idx;
			seg_d = codes_sel[last.view.idx];
		end else begin
			grid_d = GRID_BLANK;
			seg_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '0;
			out_valid <= 1'b0;
			grid_select <= GRID_BLANK;
			segment_pattern <= '0;
			busy_res <= 1'b0;
		end else if (advance) begin
			out_valid <= last.valid;
			if (last.valid) begin
				if (last.is_load) begin
					codes_q <= codes_new;
				end
				grid_select <= grid_d;
				segment_pattern <= seg_d;
				busy_res <= last.view.scan;
			end
		end
	end

endmodule
